// ----- sv/twrm_pkg.sv -----
`timescale 1ns / 1ps

package twrm_pkg;

    // Command codes carried in the request's command field.
    localparam logic [2:0] CMD_READ_WORD   = 3'd0;
    localparam logic [2:0] CMD_WRITE_WORD  = 3'd1;
    localparam logic [2:0] CMD_READ_BIT    = 3'd2;
    localparam logic [2:0] CMD_WRITE_BIT   = 3'd3;
    localparam logic [2:0] CMD_READ_FIELD  = 3'd4;
    localparam logic [2:0] CMD_WRITE_FIELD = 3'd5;

    // Top address bit marks a read frame.
    localparam logic [7:0] ADDR_READ_FLAG = 8'h80;

    localparam logic [4:0] ADDR_BITS = 5'd8;
    localparam logic [4:0] DATA_BITS = 5'd16;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_ADDR_R = 4'd1,
        PH_RDATA  = 4'd2,
        PH_GAP    = 4'd3,
        PH_ADDR_W = 4'd4,
        PH_WDATA  = 4'd5,
        PH_FINISH = 4'd6
    } twrm_phase_t;

    typedef struct packed {
        logic        start_req;
        logic [2:0]  command;
        logic [1:0]  device;
        logic [6:0]  reg_addr;
        logic [3:0]  bit_pos;
        logic [4:0]  field_length;
        logic [15:0] write_data;
        logic        sdat_in;
    } twrm_req_t;

    typedef struct packed {
        logic [3:0]  cs_n;
        logic        sclk;
        logic        sdat_out;
        logic        sdat_oe;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
        logic        status;
    } twrm_res_t;

endpackage

// ----- sv/twrm_seq.sv -----
`timescale 1ns / 1ps

module twrm_seq
    import twrm_pkg::*;
#(
    parameter int NUM_DEVICES = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  twrm_req_t req,
    output twrm_res_t res
);

    twrm_phase_t phase_reg, phase_next, cur_phase;
    logic [4:0]  cnt_reg, cnt_next, cur_cnt;
    logic        half_reg, half_next, cur_half;
    logic [7:0]  addr_reg, addr_next, cur_addr;
    logic [15:0] data_reg, data_next, cur_data;
    logic [15:0] capt_reg, capt_next;
    logic [2:0]  kind_reg, kind_next, cur_kind;
    logic [1:0]  dev_reg, dev_next, cur_dev;
    logic [3:0]  pos_reg, pos_next, cur_pos;
    logic [4:0]  len_reg, len_next, cur_len;
    logic [15:0] pend_reg, pend_next, cur_pend;
    logic        de_reg, de_next, cur_de;

    logic        bad;
    logic        acc_done;
    logic        acc_status;
    logic [15:0] shift_in;
    logic [4:0]  cnt_inc;

    function automatic logic [3:0] field_lsb(input logic [3:0] pos, input logic [4:0] len);
        field_lsb = pos - len[3:0] + 4'd1;
    endfunction

    function automatic logic [15:0] field_mask(input logic [3:0] pos, input logic [4:0] len);
        logic [4:0]  n;
        logic [16:0] ones;
        n          = (len > 5'd16) ? 5'd16 : len;
        ones       = (17'd1 << n) - 17'd1;
        field_mask = ones[15:0] << field_lsb(pos, len);
    endfunction

    function automatic logic [15:0] modify_word(input logic [15:0] w, input logic [2:0] kind,
                                                input logic [3:0] pos, input logic [4:0] len,
                                                input logic [15:0] pend);
        logic [15:0] bit_sel;
        logic [15:0] mask;
        bit_sel = 16'd1 << pos;
        mask    = field_mask(pos, len);
        if (kind == CMD_WRITE_BIT)
        begin
            modify_word = (pend != 16'd0) ? (w | bit_sel) : (w & ~bit_sel);
        end
        else
        begin
            modify_word = (w & ~mask) | ((pend << field_lsb(pos, len)) & mask);
        end
    endfunction

    // Request acceptance: a valid start while idle loads the command registers; a bad one reports done with status.
    always_comb
    begin
        cur_phase  = phase_reg;
        cur_cnt    = cnt_reg;
        cur_half   = half_reg;
        cur_addr   = addr_reg;
        cur_data   = data_reg;
        cur_kind   = kind_reg;
        cur_dev    = dev_reg;
        cur_pos    = pos_reg;
        cur_len    = len_reg;
        cur_pend   = pend_reg;
        cur_de     = de_reg;
        acc_done   = 1'b0;
        acc_status = 1'b0;
        bad = (req.command > CMD_WRITE_FIELD)
           || (int'(req.device) >= NUM_DEVICES)
           || ((req.command inside {CMD_READ_FIELD, CMD_WRITE_FIELD})
               && ((req.field_length == 5'd0)
                   || (req.field_length > ({1'b0, req.bit_pos} + 5'd1))));
        if ((phase_reg == PH_IDLE) && req.start_req)
        begin
            if (bad)
            begin
                acc_done   = 1'b1;
                acc_status = 1'b1;
            end
            else
            begin
                cur_kind = req.command;
                cur_dev  = req.device;
                cur_pos  = req.bit_pos;
                cur_len  = req.field_length;
                cur_pend = req.write_data;
                cur_cnt  = 5'd0;
                cur_half = 1'b0;
                cur_de   = 1'b1;
                if (req.command == CMD_WRITE_WORD)
                begin
                    cur_addr  = {1'b0, req.reg_addr};
                    cur_data  = req.write_data;
                    cur_phase = PH_ADDR_W;
                end
                else
                begin
                    cur_addr  = ADDR_READ_FLAG | {1'b0, req.reg_addr};
                    cur_phase = PH_ADDR_R;
                end
            end
        end
    end

    assign shift_in = {cur_data[14:0], req.sdat_in};
    assign cnt_inc  = cur_cnt + 5'd1;

    // Next state of the sequencer.
    always_comb
    begin
        phase_next = cur_phase;
        cnt_next   = cur_cnt;
        half_next  = cur_half;
        addr_next  = cur_addr;
        data_next  = cur_data;
        capt_next  = capt_reg;
        kind_next  = cur_kind;
        dev_next   = cur_dev;
        pos_next   = cur_pos;
        len_next   = cur_len;
        pend_next  = cur_pend;
        de_next    = cur_de;
        case (cur_phase)
            PH_IDLE:
            begin
            end
            PH_ADDR_R, PH_ADDR_W:
            begin
                if (cur_half)
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= ADDR_BITS)
                    begin
                        cnt_next = 5'd0;
                        if (cur_phase == PH_ADDR_R)
                        begin
                            phase_next = PH_RDATA;
                            de_next    = 1'b0;
                            data_next  = 16'd0;
                        end
                        else
                        begin
                            phase_next = PH_WDATA;
                        end
                    end
                end
                half_next = ~cur_half;
            end
            PH_RDATA:
            begin
                if (cur_half)
                begin
                    data_next = shift_in;
                    cnt_next  = cnt_inc;
                    if (cnt_inc >= DATA_BITS)
                    begin
                        cnt_next  = 5'd0;
                        capt_next = shift_in;
                        de_next   = 1'b1;
                        if ((cur_kind == CMD_WRITE_BIT) || (cur_kind == CMD_WRITE_FIELD))
                        begin
                            data_next  = modify_word(shift_in, cur_kind, cur_pos, cur_len,
                                                     cur_pend);
                            addr_next  = cur_addr & ~ADDR_READ_FLAG;
                            phase_next = PH_GAP;
                        end
                        else
                        begin
                            phase_next = PH_FINISH;
                        end
                    end
                end
                half_next = ~cur_half;
            end
            PH_GAP:
            begin
                cnt_next   = 5'd0;
                half_next  = 1'b0;
                phase_next = PH_ADDR_W;
            end
            PH_WDATA:
            begin
                if (cur_half)
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= DATA_BITS)
                    begin
                        cnt_next   = 5'd0;
                        phase_next = PH_FINISH;
                    end
                end
                half_next = ~cur_half;
            end
            PH_FINISH:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Pin levels and completion report for this tick.
    always_comb
    begin
        res.cs_n      = 4'hF;
        res.sclk      = 1'b1;
        res.sdat_out  = 1'b1;
        res.sdat_oe   = cur_de;
        res.busy_res  = 1'b0;
        res.done_res  = acc_done;
        res.read_data = 16'd0;
        res.status    = acc_status;
        case (cur_phase)
            PH_ADDR_R, PH_ADDR_W:
            begin
                res.cs_n     = ~(4'd1 << cur_dev);
                res.busy_res = 1'b1;
                res.sclk     = cur_half;
                res.sdat_out = cur_addr[~cur_cnt[2:0]];
            end
            PH_RDATA:
            begin
                res.cs_n     = ~(4'd1 << cur_dev);
                res.busy_res = 1'b1;
                res.sclk     = cur_half;
            end
            PH_GAP:
            begin
                res.busy_res = 1'b1;
            end
            PH_WDATA:
            begin
                res.cs_n     = ~(4'd1 << cur_dev);
                res.busy_res = 1'b1;
                res.sclk     = cur_half;
                res.sdat_out = cur_data[~cur_cnt[3:0]];
            end
            PH_FINISH:
            begin
                res.done_res = 1'b1;
                case (cur_kind)
                    CMD_READ_WORD:  res.read_data = capt_reg;
                    CMD_READ_BIT:   res.read_data = capt_reg & (16'd1 << cur_pos);
                    CMD_READ_FIELD: res.read_data = (capt_reg & field_mask(cur_pos, cur_len))
                                                    >> field_lsb(cur_pos, cur_len);
                    default:        res.read_data = 16'd0;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= 5'd0;
            half_reg  <= 1'b0;
            addr_reg  <= 8'd0;
            data_reg  <= 16'd0;
            capt_reg  <= 16'd0;
            kind_reg  <= 3'd0;
            dev_reg   <= 2'd0;
            pos_reg   <= 4'd0;
            len_reg   <= 5'd0;
            pend_reg  <= 16'd0;
            de_reg    <= 1'b1;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            half_reg  <= half_next;
            addr_reg  <= addr_next;
            data_reg  <= data_next;
            capt_reg  <= capt_next;
            kind_reg  <= kind_next;
            dev_reg   <= dev_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
            de_reg    <= de_next;
        end
    end

    // The data line stays released for the whole read data phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && (phase_reg == PH_RDATA)) |-> !res.sdat_oe)
        else $error("data line driven during read data phase");

    // A finish tick always returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && (phase_reg == PH_FINISH)) |=> (phase_reg == PH_IDLE))
        else $error("sequencer did not return to idle after finish");

    // A rejection is only ever reported on a start taken while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.status) |-> ((phase_reg == PH_IDLE) && req.start_req && res.done_res))
        else $error("rejection reported outside a start while idle");

    // The gap between frames deselects every device but stays busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && (phase_reg == PH_GAP)) |-> ((res.cs_n == 4'hF) && res.busy_res))
        else $error("gap tick with a device selected or not busy");

endmodule

// ----- sv/twrm_out_reg.sv -----
`timescale 1ns / 1ps

module twrm_out_reg
    import twrm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  twrm_res_t res_in,
    input  logic      out_ready,
    output logic      space,
    output logic      out_valid,
    output twrm_res_t out_data
);

    logic      valid_reg;
    twrm_res_t data_reg;

    // A new result may enter whenever the held one is gone or leaves now.
    assign space     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

endmodule

// ----- sv/three_wire_register_access_master.sv -----
`timescale 1ns / 1ps

// Three-wire register access master with one active-low chip select per device, a serial
// clock and a shared data line, offering word, bit and field reads and writes. Every
// request on the input channel is one bus tick: it carries the start fields and the level
// sampled on the data line, and it produces exactly one result carrying the pin levels for
// that tick together with busy, done, read data and status. One request is taken per clock
// cycle; its result appears in the output register on the next cycle, and in_ready stays
// high unless that register holds a result which is not being taken. A start request is
// only honoured while idle. A plain read or write frame spans 48 ticks plus one done tick;
// bit and field writes run a read frame, one gap tick and then a write frame. Rejected
// requests (unknown command, missing device, or a field whose length is zero or exceeds
// the bit position plus one) report done with status set on the tick they arrive.

module three_wire_register_access_master
    import twrm_pkg::*;
#(
    parameter int NUM_DEVICES = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  twrm_req_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output twrm_res_t out_data
);

    logic      accept;
    logic      space;
    twrm_res_t step_res;

    // The sequencer advances exactly once for every request that is taken.
    assign in_ready = space;
    assign accept   = in_valid && space;

    twrm_seq #(
        .NUM_DEVICES (NUM_DEVICES)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept),
        .req   (in_data),
        .res   (step_res)
    );

    // The result register holds each result until it is taken; while a held result waits on a
    // stalled consumer, in_ready is low and no new request is taken.
    twrm_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_in    (step_res),
        .out_ready (out_ready),
        .space     (space),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
